// ===== src/lewc_pkg.sv =====
// Shared types, constants and helper functions for the line-editing word counter.
// Depends on nothing; every other file of the block imports it.
package lewc_pkg;

  localparam int unsigned LINE_CAPACITY = 256;
  localparam int unsigned LEN_W = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(LINE_CAPACITY);
  localparam int unsigned CNT_W = 32;

  localparam logic [7:0] CODE_END       = 8'd0;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_TAB       = 8'd9;
  localparam logic [7:0] CODE_CR        = 8'd13;
  localparam logic [7:0] CODE_SPACE     = 8'd32;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_END,
    OP_BACK,
    OP_NEWLINE,
    OP_CHAR
  } op_e;

  typedef struct packed {
    op_e  op;
    logic white;
  } cmd_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CODE_SPACE) || ((c >= CODE_TAB) && (c <= CODE_CR));
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] floor_dec(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - CNT_W'(1);
  endfunction

endpackage

// ===== src/lewc_front.sv =====
// Front end: takes character transfers and classifies each byte into a command.
// Depends on lewc_pkg; feeds lewc_queue.
module lewc_front import lewc_pkg::*; (
  input  logic       in_valid_i,
  input  logic [7:0] char_code_i,
  input  logic       queue_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output cmd_t       push_cmd_o
);

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    push_cmd_o.white = is_white(char_code_i);
    priority if (char_code_i == CODE_END) begin
      push_cmd_o.op = OP_END;
    end else if (char_code_i == CODE_BACKSPACE) begin
      push_cmd_o.op = OP_BACK;
    end else if (char_code_i == CODE_NEWLINE) begin
      push_cmd_o.op = OP_NEWLINE;
    end else begin
      push_cmd_o.op = OP_CHAR;
    end
  end

endmodule

// ===== src/lewc_queue.sv =====
// Two-entry command queue that decouples the front end from the back end.
// Depends on lewc_pkg for the command type.
module lewc_queue import lewc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== src/lewc_back.sv =====
// Back end: executes commands against the counters and the per-position whitespace
// store, and holds the end-of-stream result in an output register. Depends on lewc_pkg.
module lewc_back import lewc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  cmd_t             head_cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CNT_W-1:0] line_count_o,
  output logic [CNT_W-1:0] word_count_o,
  output logic [CNT_W-1:0] char_count_o,
  output logic             line_overflow_o
);

  logic [CNT_W-1:0] lines_q, lines_d;
  logic [CNT_W-1:0] words_q, words_d;
  logic [CNT_W-1:0] chars_q, chars_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;

  // Whitespace bit of the last kept position, and of the one before it as read
  // back from the store.
  logic             top_q, top_d;
  logic             sec_q;

  logic             marks_q [LINE_CAPACITY];
  logic             mark_we;
  logic [LEN_W-1:0] rd_len;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] res_lines_q, res_words_q, res_chars_q;
  logic             res_ovf_q;
  logic             load_res;

  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = head_valid_i && ((head_cmd_i.op != OP_END) || out_free);
  assign load_res = pop_o && (head_cmd_i.op == OP_END);

  always_comb begin
    lines_d     = lines_q;
    words_d     = words_q;
    chars_d     = chars_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    top_d       = top_q;
    mark_we     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      unique case (head_cmd_i.op)
        OP_END: begin
          out_valid_d = 1'b1;
          lines_d     = '0;
          words_d     = '0;
          chars_d     = '0;
          len_d       = '0;
          ovf_d       = 1'b0;
        end
        OP_BACK: begin
          if (len_q != '0) begin
            chars_d = floor_dec(chars_q);
            len_d   = len_q - LEN_W'(1);
            top_d   = sec_q;
            if (!top_q && ((len_q == LEN_W'(1)) || sec_q)) begin
              words_d = floor_dec(words_q);
            end
          end
        end
        OP_NEWLINE: begin
          lines_d = sat_inc(lines_q);
          len_d   = '0;
        end
        OP_CHAR: begin
          if (len_q == LEN_W'(LINE_CAPACITY)) begin
            ovf_d = 1'b1;
          end else begin
            if (!head_cmd_i.white && ((len_q == '0) || top_q)) begin
              words_d = sat_inc(words_q);
            end
            chars_d = sat_inc(chars_q);
            mark_we = 1'b1;
            top_d   = head_cmd_i.white;
            len_d   = len_q + LEN_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The store is read every cycle at two below the next length, so the mark
  // under the top of the line is ready for a following backspace.
  assign rd_len  = len_d - LEN_W'(2);
  assign rd_addr = rd_len[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      marks_q[len_q[IDX_W-1:0]] <= head_cmd_i.white;
    end
    sec_q <= marks_q[rd_addr];
    top_q <= top_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_lines_q <= (chars_q != '0) ? sat_inc(lines_q) : lines_q;
      res_words_q <= words_q;
      res_chars_q <= chars_q;
      res_ovf_q   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q     <= '0;
      words_q     <= '0;
      chars_q     <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      lines_q     <= lines_d;
      words_q     <= words_d;
      chars_q     <= chars_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_count_o    = res_lines_q;
  assign word_count_o    = res_words_q;
  assign char_count_o    = res_chars_q;
  assign line_overflow_o = res_ovf_q;

endmodule

// ===== src/line_edit_word_counter.sv =====
// Top level of the line-editing word counter: front end, command queue, back end.
// Depends on lewc_pkg, lewc_front, lewc_queue and lewc_back.
//
// This block counts lines, words and characters of a byte stream the way wc does,
// but it honors backspace editing inside the current line. Each input transfer
// carries one character byte: 8 removes the last kept character of the line (and
// one word if that character began a word), 10 counts a line and empties the line,
// 0 ends the stream, and every other byte is an ordinary character. Whitespace is
// space, tab, line feed, vertical tab, form feed and carriage return. At the end of
// the stream one result transfer carries the line count (plus one if any characters
// were counted), the word count, the character count and a flag that says whether
// a character was dropped because the line held LINE_CAPACITY characters already;
// all counts then return to zero. The counts saturate at 2^32-1. The block takes one
// byte per clock cycle: the front end classifies a byte in the cycle it arrives and
// writes it into a two-entry command queue, and the back end executes one command a
// cycle, with the line's whitespace marks in a memory that is written at the line
// end and read, registered, two positions below it, so a run of backspaces also
// proceeds one per cycle. Only an end-of-stream byte can wait in the back end, and
// only while the previous result sits unread in the output register; the input
// stalls once the queue has filled behind it. The line store needs no clearing after
// reset, since a position's mark is used only after it has been written.
module line_edit_word_counter import lewc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       char_code_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CNT_W-1:0] line_count_o,
  output logic [CNT_W-1:0] word_count_o,
  output logic [CNT_W-1:0] char_count_o,
  output logic             line_overflow_o
);

  logic queue_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  lewc_front u_front (
    .in_valid_i   (in_valid_i),
    .char_code_i  (char_code_i),
    .queue_full_i (queue_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  lewc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  lewc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_cmd_i      (head_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .line_count_o    (line_count_o),
    .word_count_o    (word_count_o),
    .char_count_o    (char_count_o),
    .line_overflow_o (line_overflow_o)
  );

endmodule
